FILE: hdl/plt_pkg.sv
package plt_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int VALUE_WIDTH_DEF = 32;

	localparam logic [2:0] OP_INSERT = 3'd0;
	localparam logic [2:0] OP_DELETE = 3'd1;
	localparam logic [2:0] OP_GET = 3'd2;
	localparam logic [2:0] OP_SET = 3'd3;
	localparam logic [2:0] OP_FIND = 3'd4;
	localparam logic [2:0] OP_DELVAL = 3'd5;
	localparam logic [2:0] OP_PUSH = 3'd6;
	localparam logic [2:0] OP_POP = 3'd7;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_RANGE = 3'd1;
	localparam logic [2:0] ST_FULL = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_EMPTY = 3'd4;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		logic ins;
		logic rem;
		logic wr;
	} cell_ctl_t;

	typedef struct packed {
		logic [2:0] status;
		logic [31:0] data;
		logic [3:0] index;
		logic [4:0] count;
	} res_t;

endpackage

FILE: hdl/plt_req_if.sv
interface plt_req_if;
	logic valid;
	logic ready;
	logic [2:0] op;
	logic [4:0] pos;
	logic [31:0] value;

	modport source (output valid, output op, output pos, output value, input ready);
	modport sink (input valid, input op, input pos, input value, output ready);
endinterface

FILE: hdl/plt_rsp_if.sv
interface plt_rsp_if;
	logic valid;
	logic ready;
	logic [2:0] status;
	logic [31:0] data;
	logic [3:0] index;
	logic [4:0] count;

	modport source (output valid, output status, output data, output index, output count,
		input ready);
	modport sink (input valid, input status, input data, input index, input count,
		output ready);
endinterface

FILE: hdl/plt_cell.sv
module plt_cell #(
	parameter int VALUE_WIDTH = plt_pkg::VALUE_WIDTH_DEF,
	parameter int XW = 5,
	parameter int IDX = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  plt_pkg::cell_ctl_t ctl,
	input  logic [XW-1:0] pos,
	input  logic [XW-1:0] cnt,
	input  logic [VALUE_WIDTH-1:0] wval,
	input  logic [VALUE_WIDTH-1:0] left_in,
	input  logic [VALUE_WIDTH-1:0] right_in,
	output logic [VALUE_WIDTH-1:0] entry,
	output logic match
);

	localparam logic [XW-1:0] MY = XW'(IDX);

	logic [VALUE_WIDTH-1:0] entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (ctl.ins) begin
			if (MY == pos) begin
				entry_q <= wval;
			end else if (MY > pos && MY <= cnt) begin
				entry_q <= left_in;
			end
		end else if (ctl.rem) begin
			// Entries past the count are always zero, so the tail pulls in zeros.
			if (MY >= pos) begin
				entry_q <= right_in;
			end
		end else if (ctl.wr) begin
			if (MY == pos) begin
				entry_q <= wval;
			end else if (MY >= cnt && MY < pos) begin
				entry_q <= '0;
			end
		end
	end

	assign entry = entry_q;
	assign match = (entry_q == wval) && (MY < cnt);

endmodule

FILE: hdl/positional_list_table_top.sv
// Positional operations (insert, delete, get, set, push, pop): result registered in the output
// stage together with the cell chain update; one item per cycle while the skid entry is empty.
// Find and delete by value: the match vector is scanned eight cells per cycle, lowest group
// first, and no new item is taken until the scan has produced its result.
// A two-entry output stage lets a new item enter while one result waits to be taken.
// arst_n clears every entry and the count asynchronously; the block is ready right after.
module positional_list_table_top #(
	parameter int CAPACITY = plt_pkg::CAPACITY_DEF,
	parameter int VALUE_WIDTH = plt_pkg::VALUE_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	plt_req_if.sink req,
	plt_rsp_if.source rsp
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);
	localparam int XW = (CW > 5) ? CW : 5;
	localparam int NG = (CAPACITY + 7) / 8;
	localparam int GW = (NG > 1) ? $clog2(NG) : 1;
	localparam int MW = NG * 8;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_SCAN = 1'b1;

	logic state_q;
	logic [CW-1:0] cnt_q;
	logic [MW-1:0] mv_q;
	logic [GW-1:0] g_q;
	logic dv_q;
	plt_pkg::res_t out_q, hold_q;
	logic out_v_q, hold_v_q;

	logic [VALUE_WIDTH-1:0] ent [CAPACITY];
	logic [CAPACITY-1:0] mt;
	logic [VALUE_WIDTH-1:0] wval;
	plt_pkg::cell_ctl_t ctl;
	logic [XW-1:0] cpos, pos_x, cnt_x;
	logic [CW-1:0] cnt_n;
	logic [IW-1:0] rd_idx, sidx;
	logic [VALUE_WIDTH-1:0] rd_data;
	logic [2:0] first;
	logic hit, last, acc, res_v;
	plt_pkg::res_t res;

	assign acc = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE) && !hold_v_q;
	assign wval = VALUE_WIDTH'(req.value);
	assign pos_x = XW'(req.pos);
	assign cnt_x = XW'(cnt_q);

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			logic [VALUE_WIDTH-1:0] lft, rgt;
			if (gi == 0) begin : g_first
				assign lft = '0;
			end else begin : g_mid_l
				assign lft = ent[gi-1];
			end
			if (gi == CAPACITY - 1) begin : g_last
				assign rgt = '0;
			end else begin : g_mid_r
				assign rgt = ent[gi+1];
			end
			plt_cell #(
				.VALUE_WIDTH(VALUE_WIDTH),
				.XW(XW),
				.IDX(gi)
			) u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.ctl(ctl),
				.pos(cpos),
				.cnt(cnt_x),
				.wval(wval),
				.left_in(lft),
				.right_in(rgt),
				.entry(ent[gi]),
				.match(mt[gi])
			);
		end
	endgenerate

	assign rd_data = ent[rd_idx];

	// Lowest match in the current group of eight.
	always_comb begin
		first = '0;
		for (int k = 7; k >= 0; k--) begin
			if (mv_q[k]) begin
				first = 3'(k);
			end
		end
	end
	assign hit = |mv_q[7:0];
	assign last = (g_q == GW'(NG - 1));
	assign sidx = IW'({g_q, first});

	always_comb begin
		ctl = '0;
		cpos = pos_x;
		rd_idx = IW'(pos_x);
		cnt_n = cnt_q;
		res_v = 1'b0;
		res = '0;
		res.status = plt_pkg::ST_OK;
		if (state_q == S_SCAN) begin
			cpos = XW'(sidx);
			rd_idx = sidx;
			if (hit) begin
				res_v = 1'b1;
				res.index = 4'(sidx);
				if (dv_q) begin
					ctl.rem = 1'b1;
					res.data = 32'(rd_data);
					cnt_n = cnt_q - CW'(1);
				end
			end else if (last) begin
				res_v = 1'b1;
				res.status = plt_pkg::ST_NOTFOUND;
			end
		end else if (acc) begin
			unique case (req.op)
				plt_pkg::OP_INSERT: begin
					res_v = 1'b1;
					if (pos_x > cnt_x) begin
						res.status = plt_pkg::ST_RANGE;
					end else if (cnt_q == CW'(CAPACITY)) begin
						res.status = plt_pkg::ST_FULL;
					end else begin
						ctl.ins = 1'b1;
						cnt_n = cnt_q + CW'(1);
					end
				end
				plt_pkg::OP_DELETE: begin
					res_v = 1'b1;
					if (pos_x >= cnt_x) begin
						res.status = plt_pkg::ST_RANGE;
					end else begin
						ctl.rem = 1'b1;
						res.data = 32'(rd_data);
						cnt_n = cnt_q - CW'(1);
					end
				end
				plt_pkg::OP_GET: begin
					res_v = 1'b1;
					if (pos_x >= cnt_x) begin
						res.status = plt_pkg::ST_RANGE;
					end else begin
						res.data = 32'(rd_data);
					end
				end
				plt_pkg::OP_SET: begin
					res_v = 1'b1;
					if (pos_x >= XW'(CAPACITY)) begin
						res.status = plt_pkg::ST_RANGE;
					end else begin
						ctl.wr = 1'b1;
						if (pos_x >= cnt_x) begin
							cnt_n = CW'(pos_x + XW'(1));
						end
					end
				end
				plt_pkg::OP_FIND, plt_pkg::OP_DELVAL: begin
					// Result comes from the scan.
				end
				plt_pkg::OP_PUSH: begin
					res_v = 1'b1;
					cpos = cnt_x;
					if (cnt_q == CW'(CAPACITY)) begin
						res.status = plt_pkg::ST_FULL;
					end else begin
						ctl.ins = 1'b1;
						cnt_n = cnt_q + CW'(1);
					end
				end
				plt_pkg::OP_POP: begin
					res_v = 1'b1;
					cpos = XW'(cnt_q - CW'(1));
					rd_idx = IW'(cnt_q - CW'(1));
					if (cnt_q == '0) begin
						res.status = plt_pkg::ST_EMPTY;
					end else begin
						ctl.rem = 1'b1;
						res.data = 32'(rd_data);
						cnt_n = cnt_q - CW'(1);
					end
				end
				default: begin
				end
			endcase
		end
		res.count = 5'(cnt_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			g_q <= '0;
			dv_q <= 1'b0;
		end else begin
			cnt_q <= cnt_n;
			if (state_q == S_SCAN) begin
				if (hit || last) begin
					state_q <= S_IDLE;
				end else begin
					g_q <= g_q + GW'(1);
				end
			end else if (acc && (req.op == plt_pkg::OP_FIND || req.op == plt_pkg::OP_DELVAL)) begin
				state_q <= S_SCAN;
				g_q <= '0;
				dv_q <= (req.op == plt_pkg::OP_DELVAL);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SCAN) begin
			mv_q <= mv_q >> 8;
		end else if (acc) begin
			mv_q <= MW'(mt);
		end
	end

	// Output register with one skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			hold_v_q <= 1'b0;
		end else if (hold_v_q && (!out_v_q || rsp.ready)) begin
			out_v_q <= 1'b1;
			hold_v_q <= 1'b0;
		end else if (res_v) begin
			if (!out_v_q || rsp.ready) begin
				out_v_q <= 1'b1;
			end else begin
				hold_v_q <= 1'b1;
			end
		end else if (out_v_q && rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (hold_v_q && (!out_v_q || rsp.ready)) begin
			out_q <= hold_q;
		end else if (res_v) begin
			if (!out_v_q || rsp.ready) begin
				out_q <= res;
			end else begin
				hold_q <= res;
			end
		end
	end

	assign rsp.valid = out_v_q;
	assign rsp.status = out_q.status;
	assign rsp.data = out_q.data;
	assign rsp.index = out_q.index;
	assign rsp.count = out_q.count;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count exceeds capacity");

	a_hold_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		hold_v_q |-> out_v_q)
		else $error("skid entry valid with empty output register");

	a_tail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q < CW'(CAPACITY)) |-> (ent[CAPACITY-1] == '0))
		else $error("entry past the count is not zero");

	a_scan_group: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (g_q <= GW'(NG - 1)))
		else $error("scan ran past the last group");

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && req.op != plt_pkg::OP_FIND && req.op != plt_pkg::OP_DELVAL) |-> res_v)
		else $error("positional operation produced no result");

endmodule
